// ===== sv/mcso_pkg.sv =====
// ----------------------------------------------------------------------------
// mcso_pkg
// Types, constants and helpers shared by the magic circle oscillator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mcso_pkg;

	localparam int SAMPLE_WIDTH  = 24;
	localparam int EPS_WIDTH     = 24;
	localparam int LEN_WIDTH     = 7;
	localparam int MAX_BLOCK_LEN = 64;
	localparam int IDX_WIDTH     = $clog2(MAX_BLOCK_LEN);

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	// restoring divider for the ramp slope, one quotient bit per cycle
	localparam int DIV_STEPS = EPS_WIDTH;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// eps (unsigned, zero-extended) times sample
	localparam int PROD_W = EPS_WIDTH + 1 + SAMPLE_WIDTH;
	localparam int FRAC_W = EPS_WIDTH - 1;
	localparam int RND_W  = PROD_W - FRAC_W;
	localparam int SUM_W  = RND_W + 1;

	typedef struct packed {
		logic [EPS_WIDTH-1:0]           new_epsilon;
		logic                           hold;
		logic signed [SAMPLE_WIDTH-1:0] start_sin;
		logic signed [SAMPLE_WIDTH-1:0] start_cos;
	} req_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           last;
	} smp_t;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_FIXED,
		CMD_RAMP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                      kind;
		logic [EPS_WIDTH-1:0]           eps_old;
		logic [EPS_WIDTH-1:0]           eps_new;
		logic signed [SAMPLE_WIDTH-1:0] start_sin;
		logic signed [SAMPLE_WIDTH-1:0] start_cos;
		logic [LEN_WIDTH-1:0]           len;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} cmdq_status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_DFIX,
		BK_MUL1,
		BK_QUPD,
		BK_MUL2,
		BK_EMIT
	} bk_state_t;

	// clamp a wide signed sum into the sample range
	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
		input logic signed [SUM_W-1:0] v
	);
		logic [SUM_W-SAMPLE_WIDTH:0] top;
		top = v[SUM_W-1:SAMPLE_WIDTH-1];
		if ((&top) || !(|top)) begin
			return v[SAMPLE_WIDTH-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
	endfunction

	// Q4.45 product to Q4.22 (the sample scale), round half up
	function automatic logic signed [RND_W-1:0] round_prod(
		input logic signed [PROD_W-1:0] p
	);
		logic signed [PROD_W-1:0] t;
		t = p + $signed({{(PROD_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}});
		return t[PROD_W-1:FRAC_W];
	endfunction

endpackage

`default_nettype wire

// ===== sv/mcso_front.sv =====
// ----------------------------------------------------------------------------
// mcso_front
// Takes requests, tracks start and epsilon, queues one command per block.
// ----------------------------------------------------------------------------
`default_nettype none

module mcso_front import mcso_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wen,
	input  wire logic [LEN_WIDTH-1:0] cfg_wdata,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire req_t                 req,
	input  wire cmdq_status_t         q_status,
	output logic                      push,
	output cmd_t                      push_cmd
);

	logic [LEN_WIDTH-1:0] block_length_q;
	logic                 started_q;
	logic [EPS_WIDTH-1:0] cur_eps_q;
	logic                 accept;
	logic                 ramp;
	logic [LEN_WIDTH-1:0] len;

	assign req_stall = q_status.full;
	assign accept    = req_valid && !q_status.full;
	assign push      = accept && !(req.hold && !started_q);
	assign ramp      = started_q && !req.hold && (req.new_epsilon != cur_eps_q);

	always_comb begin
		if (block_length_q == '0) begin
			len = LEN_WIDTH'(1);
		end else if (block_length_q > LEN_WIDTH'(MAX_BLOCK_LEN)) begin
			len = LEN_WIDTH'(MAX_BLOCK_LEN);
		end else begin
			len = block_length_q;
		end
	end

	always_comb begin
		push_cmd.start_sin = req.start_sin;
		push_cmd.start_cos = req.start_cos;
		push_cmd.eps_new   = req.new_epsilon;
		push_cmd.len       = len;
		if (!started_q) begin
			push_cmd.kind    = CMD_LOAD;
			push_cmd.eps_old = req.new_epsilon;
		end else if (ramp) begin
			push_cmd.kind    = CMD_RAMP;
			push_cmd.eps_old = cur_eps_q;
		end else begin
			push_cmd.kind    = CMD_FIXED;
			push_cmd.eps_old = cur_eps_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= LEN_WIDTH'(MAX_BLOCK_LEN);
			started_q      <= 1'b0;
			cur_eps_q      <= '0;
		end else begin
			if (cfg_wen) begin
				block_length_q <= cfg_wdata;
			end
			if (push && (!started_q || ramp)) begin
				started_q <= 1'b1;
				cur_eps_q <= req.new_epsilon;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/mcso_cmdq.sv =====
// ----------------------------------------------------------------------------
// mcso_cmdq
// Short command queue between the request front and the sample engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mcso_cmdq import mcso_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire cmd_t  push_cmd,
	input  wire logic  pop,
	output cmd_t       head,
	output cmdq_status_t status
);

	cmd_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign status.empty = (cnt_q == '0);

	function automatic logic [CMDQ_PTR_W-1:0] ptr_inc(input logic [CMDQ_PTR_W-1:0] p);
		if (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full && !pop))
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && status.empty))
		else $error("command popped from an empty queue");

endmodule

`default_nettype wire

// ===== sv/mcso_engine.sv =====
// ----------------------------------------------------------------------------
// mcso_engine
// Runs one block per command: ramp slope divide, then the magic circle
// recurrence on one shared multiplier, into a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module mcso_engine import mcso_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cmdq_status_t q_status,
	input  wire cmd_t         head,
	output logic              pop,
	output logic              smp_valid,
	input  wire logic         smp_stall,
	output smp_t              smp
);

	bk_state_t state_q, state_d;

	logic [LEN_WIDTH-1:0]           len_q;
	logic [IDX_WIDTH-1:0]           idx_q;
	logic [EPS_WIDTH-1:0]           eps_q;
	logic signed [EPS_WIDTH:0]      qd_q;      // slope quotient per sample
	logic [LEN_WIDTH-1:0]           rd_q;      // slope remainder per sample
	logic [LEN_WIDTH-1:0]           racc_q;    // running remainder
	logic                           dneg_q;
	logic [LEN_WIDTH-1:0]           div_rem_q;
	logic [EPS_WIDTH-1:0]           div_quo_q;
	logic [DIV_CNT_W-1:0]           div_cnt_q;
	logic signed [SAMPLE_WIDTH-1:0] in_phase_q;
	logic signed [SAMPLE_WIDTH-1:0] quad_q;
	logic signed [PROD_W-1:0]       prod_q;
	logic                           out_valid_q;
	smp_t                           out_q;

	logic                           slot_free;
	logic                           emit;
	logic                           is_last;
	logic                           div_done;
	logic signed [EPS_WIDTH:0]      diff;
	logic [LEN_WIDTH:0]             rem_sh;
	logic                           rem_ge;
	logic [LEN_WIDTH:0]             racc_sum;
	logic                           wrap;
	logic signed [EPS_WIDTH+1:0]    eps_sum;
	logic signed [SAMPLE_WIDTH-1:0] mul_x;
	logic signed [RND_W-1:0]        rnd;
	logic signed [SAMPLE_WIDTH-1:0] in_phase_nx;
	logic signed [SAMPLE_WIDTH-1:0] quad_nx;

	assign smp_valid = out_valid_q;
	assign smp       = out_q;
	assign slot_free = !out_valid_q || !smp_stall;
	assign is_last   = ({1'b0, idx_q} + 1'b1) == len_q;
	assign div_done  = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	assign diff   = $signed({1'b0, head.eps_new}) - $signed({1'b0, head.eps_old});
	assign rem_sh = {div_rem_q, div_quo_q[EPS_WIDTH-1]};
	assign rem_ge = rem_sh >= {1'b0, len_q};

	assign racc_sum = {1'b0, racc_q} + {1'b0, rd_q};
	assign wrap     = racc_sum >= {1'b0, len_q};
	assign eps_sum  = $signed({2'b00, eps_q}) + $signed({qd_q[EPS_WIDTH], qd_q})
		+ $signed({{(EPS_WIDTH+1){1'b0}}, wrap});

	assign mul_x       = (state_q == BK_MUL1) ? in_phase_q : quad_q;
	assign rnd         = round_prod(prod_q);
	assign quad_nx     = sat_sample($signed({{(SUM_W-SAMPLE_WIDTH){quad_q[SAMPLE_WIDTH-1]}},
		quad_q}) - $signed({rnd[RND_W-1], rnd}));
	assign in_phase_nx = sat_sample(
		$signed({{(SUM_W-SAMPLE_WIDTH){in_phase_q[SAMPLE_WIDTH-1]}}, in_phase_q})
		+ $signed({rnd[RND_W-1], rnd}));

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		emit    = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					pop     = 1'b1;
					state_d = (head.kind == CMD_RAMP) ? BK_DIV : BK_MUL1;
				end
			end
			BK_DIV: begin
				if (div_done) begin
					state_d = BK_DFIX;
				end
			end
			BK_DFIX: state_d = BK_MUL1;
			BK_MUL1: state_d = BK_QUPD;
			BK_QUPD: state_d = BK_MUL2;
			BK_MUL2: state_d = BK_EMIT;
			BK_EMIT: begin
				if (slot_free) begin
					emit    = 1'b1;
					state_d = is_last ? BK_IDLE : BK_MUL1;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
			in_phase_q  <= '0;
			quad_q      <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!smp_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop && head.kind == CMD_LOAD) begin
				in_phase_q <= head.start_sin;
				quad_q     <= head.start_cos;
			end
			if (state_q == BK_QUPD) begin
				quad_q <= quad_nx;
			end
			if (emit) begin
				in_phase_q <= in_phase_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			len_q     <= head.len;
			eps_q     <= head.eps_old;
			idx_q     <= '0;
			racc_q    <= '0;
			qd_q      <= '0;
			rd_q      <= '0;
			dneg_q    <= diff[EPS_WIDTH];
			div_rem_q <= '0;
			div_quo_q <= diff[EPS_WIDTH] ? EPS_WIDTH'(-diff) : diff[EPS_WIDTH-1:0];
			div_cnt_q <= '0;
		end
		if (state_q == BK_DIV) begin
			div_rem_q <= rem_ge ? LEN_WIDTH'(rem_sh - {1'b0, len_q}) : rem_sh[LEN_WIDTH-1:0];
			div_quo_q <= {div_quo_q[EPS_WIDTH-2:0], rem_ge};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
		if (state_q == BK_DFIX) begin
			// floor division: quotient kept for a positive slope, rounded down for a negative one
			if (!dneg_q) begin
				qd_q <= $signed({1'b0, div_quo_q});
				rd_q <= div_rem_q;
			end else if (div_rem_q != '0) begin
				qd_q <= -$signed({1'b0, div_quo_q}) - $signed({{EPS_WIDTH{1'b0}}, 1'b1});
				rd_q <= len_q - div_rem_q;
			end else begin
				qd_q <= -$signed({1'b0, div_quo_q});
				rd_q <= '0;
			end
		end
		if (state_q == BK_MUL1 || state_q == BK_MUL2) begin
			prod_q <= $signed({1'b0, eps_q}) * mul_x;
		end
		if (emit) begin
			out_q.sample <= in_phase_nx;
			out_q.last   <= is_last;
			idx_q        <= idx_q + 1'b1;
			racc_q       <= wrap ? LEN_WIDTH'(racc_sum - {1'b0, len_q})
				: racc_sum[LEN_WIDTH-1:0];
			eps_q        <= eps_sum[EPS_WIDTH-1:0];
		end
	end

	a_idx_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_MUL1 || state_q == BK_EMIT) |-> ({1'b0, idx_q} < len_q))
		else $error("sample index ran past block length");

	a_racc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EMIT) |-> (racc_q < len_q && rd_q < len_q))
		else $error("ramp remainder out of range");

	a_last_ends_block: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && is_last) |=> (state_q == BK_IDLE && out_valid_q && out_q.last))
		else $error("block did not close on its last sample");

endmodule

`default_nettype wire

// ===== sv/magic_circle_sine_oscillator_unit.sv =====
// ----------------------------------------------------------------------------
// magic_circle_sine_oscillator_unit
// Block-based Gordon-Smith quadrature sine oscillator, Q1.23 eps, Q2.22 out.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid/req_stall/req): one transaction asks for one block
//    of block_length samples. The first non-hold request loads start_sin,
//    start_cos and epsilon; a hold request before that is taken and dropped.
//  - smp channel (smp_valid/smp_stall/smp): one transaction per sample,
//    smp.last marks the final sample of the block.
//  - cfg_wen/cfg_wdata: writes block_length (0 acts as 1, above 64 as 64);
//    write only while idle. Resets to 64.
//  - Flow: a request is taken into a two-entry command queue at once. The
//    engine dispatches a command from IDLE; when epsilon ramps, the slope
//    divider runs in DIV (one quotient bit per cycle) and DFIX fixes the
//    sign. Each sample then runs through MUL1, QUPD, MUL2 and EMIT (two
//    dependent passes through the one 25x24 multiplier, each followed by a
//    round/saturate step); EMIT waits while the output register is held.
//  - A stalled sample sits in the output register; the engine computes the
//    next sample and waits for that register, while the front keeps taking
//    requests until the queue is full, then raises req_stall.
//  - Reset clears the start flag, epsilon, oscillator state and queue.
// ----------------------------------------------------------------------------
`default_nettype none

module magic_circle_sine_oscillator_unit import mcso_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wen,
	input  wire logic [LEN_WIDTH-1:0] cfg_wdata,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire req_t                 req,
	output logic                      smp_valid,
	input  wire logic                 smp_stall,
	output smp_t                      smp
);

	cmdq_status_t q_status;
	logic         push;
	cmd_t         push_cmd;
	logic         pop;
	cmd_t         head;

	// front: config register, start flag and epsilon tracking, classification
	mcso_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_status  (q_status),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	// decouples request intake from sample generation
	mcso_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	// back: ramp slope divide, recurrence, output register
	mcso_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head      (head),
		.pop       (pop),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp       (smp)
	);

endmodule

`default_nettype wire
